FILE: hw/rtl/parstr_pkg.sv
// ----------------------------------------------------------------------------
// parstr_pkg
// Shared constants for the polygon area / right-angle stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package parstr_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_BITS_DEF   = 16;
    localparam int MIN_VERTICES     = 3;

    localparam int IN_COORD_BITS    = 16;
    localparam int AREA_BITS        = 40;
    localparam int COUNT_BITS       = 9;
    localparam int RESULT_BITS      = AREA_BITS + COUNT_BITS + 2;
    localparam int S_TDATA_BITS     = 2 * IN_COORD_BITS;
    localparam int M_TDATA_BITS     = ((RESULT_BITS + 7) / 8) * 8;

    localparam int FIFO_DEPTH       = 4;

endpackage

`default_nettype wire

FILE: hw/rtl/polygon_area_right_angle_stream_top.sv
// ----------------------------------------------------------------------------
// polygon_area_right_angle_stream_top
// Streaming shoelace area and right-angle check, one polygon at a time.
//
// Input stream: one vertex per word, x in s_tdata[15:0], y in s_tdata[31:16],
// s_tlast on the final vertex of a polygon. One result word per polygon leaves
// on the master side after the last vertex: twice the absolute area
// (saturated at 40 bits), the vertex count, a right-angle flag and an
// overflow flag for polygons longer than MAX_VERTICES.
// Throughput: one vertex per cycle while s_tready is high. All edge and dot
// products are formed in parallel straight from s_tdata into the first
// register stage, the second stage accumulates and closes the polygon, then
// magnitude and saturation feed a 4-word result queue. m_tvalid rises once
// the closing result is written into that queue.
// A stalled receiver only fills the result queue; vertices keep flowing until
// four results are pending or in flight, then s_tready drops.
// Reset (aresetn low, synchronous) empties the pipeline and the queue and
// starts a fresh polygon.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_area_right_angle_stream_top
    import parstr_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // [15:0] vertex_x, [31:16] vertex_y
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,
    input  wire logic                    s_tlast,

    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // [39:0] twice_area, [48:40] vertex_count, [49] has_right_angle,
    // [50] too_many_vertices, [55:51] zero
    output logic [M_TDATA_BITS-1:0]      m_tdata
);

    localparam int CW   = (COORD_BITS > IN_COORD_BITS) ? IN_COORD_BITS + 1 : COORD_BITS;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int AW   = PW + $clog2(MAX_VERTICES) + 1;
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int PTRW = $clog2(FIFO_DEPTH);
    localparam int FCW  = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic                   ovf;
        logic                   dot1_en;
        logic                   close_en;
        logic signed [PW-1:0]   e1;
        logic signed [PW-1:0]   d1a;
        logic signed [PW-1:0]   d1b;
        logic signed [PW-1:0]   e2;
        logic signed [PW-1:0]   d2a;
        logic signed [PW-1:0]   d2b;
        logic signed [PW-1:0]   d3a;
        logic signed [PW-1:0]   d3b;
        logic [CNTW-1:0]        count;
    } prod_t;

    typedef struct packed {
        logic                   valid;
        logic signed [AW-1:0]   sum;
        logic [CNTW-1:0]        count;
        logic                   right;
        logic                   ovf;
    } fin_t;

    // ---------------- input side: vertex state and products ----------------
    logic signed [CW-1:0] cur_x, cur_y;

    generate
        if (COORD_BITS > IN_COORD_BITS) begin : g_wide
            assign cur_x = signed'({1'b0, s_tdata[IN_COORD_BITS-1:0]});
            assign cur_y = signed'({1'b0, s_tdata[2*IN_COORD_BITS-1:IN_COORD_BITS]});
        end else begin : g_narrow
            assign cur_x = signed'(s_tdata[CW-1:0]);
            assign cur_y = signed'(s_tdata[IN_COORD_BITS+CW-1:IN_COORD_BITS]);
        end
    endgenerate

    logic signed [CW-1:0] first_x_reg, first_y_reg, second_x_reg, second_y_reg;
    logic signed [CW-1:0] older_x_reg, older_y_reg, prev_x_reg, prev_y_reg;
    logic [CNTW-1:0]      count_reg;

    logic                 s_fire;
    logic                 absorb;
    logic [CNTW-1:0]      count_next;
    logic signed [CW-1:0] o2_x, o2_y, q2_x, q2_y;
    prod_t                prod_next, prod_reg;

    assign s_fire = s_tvalid && s_tready;
    assign absorb = count_reg < CNTW'(MAX_VERTICES);
    assign count_next = absorb ? count_reg + CNTW'(1) : count_reg;

    // vertices around the closing edge, after this word is taken in
    assign o2_x = absorb ? prev_x_reg : older_x_reg;
    assign o2_y = absorb ? prev_y_reg : older_y_reg;
    assign q2_x = absorb ? cur_x : prev_x_reg;
    assign q2_y = absorb ? cur_y : prev_y_reg;

    always_comb begin
        prod_next          = '0;
        prod_next.valid    = s_fire;
        prod_next.last     = s_tlast;
        prod_next.ovf      = !absorb;
        prod_next.dot1_en  = absorb && (count_reg >= CNTW'(2));
        prod_next.close_en = s_tlast && (count_next >= CNTW'(MIN_VERTICES));
        prod_next.count    = count_next;
        if (absorb && (count_reg != '0)) begin
            prod_next.e1 = (PW'(prev_x_reg) + PW'(cur_x)) * (PW'(prev_y_reg) - PW'(cur_y));
        end
        prod_next.d1a = (PW'(older_x_reg) - PW'(prev_x_reg)) * (PW'(cur_x) - PW'(prev_x_reg));
        prod_next.d1b = (PW'(older_y_reg) - PW'(prev_y_reg)) * (PW'(cur_y) - PW'(prev_y_reg));
        if (prod_next.close_en) begin
            prod_next.e2 = (PW'(q2_x) + PW'(first_x_reg)) * (PW'(q2_y) - PW'(first_y_reg));
        end
        prod_next.d2a = (PW'(o2_x) - PW'(q2_x)) * (PW'(first_x_reg) - PW'(q2_x));
        prod_next.d2b = (PW'(o2_y) - PW'(q2_y)) * (PW'(first_y_reg) - PW'(q2_y));
        prod_next.d3a = (PW'(q2_x) - PW'(first_x_reg)) * (PW'(second_x_reg) - PW'(first_x_reg));
        prod_next.d3b = (PW'(q2_y) - PW'(first_y_reg)) * (PW'(second_y_reg) - PW'(first_y_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            prod_reg.valid <= 1'b0;
        end else begin
            prod_reg <= prod_next;
            if (s_fire) begin
                if (s_tlast) begin
                    count_reg <= '0;
                end else begin
                    count_reg <= count_next;
                end
            end
        end
        if (s_fire && absorb) begin
            if (count_reg == '0) begin
                first_x_reg <= cur_x;
                first_y_reg <= cur_y;
            end
            if (count_reg == CNTW'(1)) begin
                second_x_reg <= cur_x;
                second_y_reg <= cur_y;
            end
            older_x_reg <= prev_x_reg;
            older_y_reg <= prev_y_reg;
            prev_x_reg  <= cur_x;
            prev_y_reg  <= cur_y;
        end
    end

    // ---------------- accumulate and close ----------------
    logic signed [AW-1:0] area_sum_reg, area_sum_next;
    logic                 right_seen_reg, right_seen_next;
    logic                 ovf_reg, ovf_next;
    logic                 dot1_zero, dot2_zero, dot3_zero;
    logic signed [AW-1:0] area_now;
    logic                 right_now;
    fin_t                 fin_next, fin_reg;

    assign dot1_zero = ((PW+1)'(prod_reg.d1a) + (PW+1)'(prod_reg.d1b)) == '0;
    assign dot2_zero = ((PW+1)'(prod_reg.d2a) + (PW+1)'(prod_reg.d2b)) == '0;
    assign dot3_zero = ((PW+1)'(prod_reg.d3a) + (PW+1)'(prod_reg.d3b)) == '0;
    assign area_now  = area_sum_reg + AW'(prod_reg.e1);
    assign right_now = right_seen_reg || (prod_reg.dot1_en && dot1_zero);

    always_comb begin
        area_sum_next   = area_sum_reg;
        right_seen_next = right_seen_reg;
        ovf_next        = ovf_reg;
        fin_next        = '0;
        if (prod_reg.valid) begin
            area_sum_next   = area_now;
            right_seen_next = right_now;
            ovf_next        = ovf_reg || prod_reg.ovf;
            if (prod_reg.last) begin
                fin_next.valid  = 1'b1;
                fin_next.count  = prod_reg.count;
                fin_next.ovf    = ovf_reg || prod_reg.ovf;
                if (prod_reg.close_en) begin
                    fin_next.sum   = area_now + AW'(prod_reg.e2);
                    fin_next.right = right_now || dot2_zero || dot3_zero;
                end
                area_sum_next   = '0;
                right_seen_next = 1'b0;
                ovf_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_sum_reg   <= '0;
            right_seen_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            fin_reg.valid  <= 1'b0;
        end else begin
            area_sum_reg   <= area_sum_next;
            right_seen_reg <= right_seen_next;
            ovf_reg        <= ovf_next;
            fin_reg        <= fin_next;
        end
    end

    // ---------------- magnitude, saturation, result queue ----------------
    logic [AW-1:0]          mag;
    logic [AREA_BITS-1:0]   area_out;
    logic [COUNT_BITS-1:0]  count_out;
    logic [RESULT_BITS-1:0] result_word;

    assign mag = fin_reg.sum[AW-1] ? unsigned'(-fin_reg.sum) : unsigned'(fin_reg.sum);

    generate
        if (AW > AREA_BITS) begin : g_sat
            assign area_out = (|mag[AW-1:AREA_BITS]) ? '1 : mag[AREA_BITS-1:0];
        end else begin : g_nosat
            assign area_out = AREA_BITS'(mag);
        end
        if (CNTW >= COUNT_BITS) begin : g_cnt_cut
            assign count_out = fin_reg.count[COUNT_BITS-1:0];
        end else begin : g_cnt_ext
            assign count_out = COUNT_BITS'(fin_reg.count);
        end
    endgenerate

    assign result_word = {fin_reg.ovf, fin_reg.right, count_out, area_out};

    logic [RESULT_BITS-1:0] fifo_mem [FIFO_DEPTH];
    logic [PTRW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [FCW-1:0]         fifo_count_reg, fifo_count_next;
    logic [FCW-1:0]         pending;
    logic                   push, pop;

    assign push = fin_reg.valid;
    assign pop  = m_tvalid && m_tready;

    assign pending = fifo_count_reg
                   + FCW'(prod_reg.valid && prod_reg.last)
                   + FCW'(fin_reg.valid);
    assign s_tready = pending < FCW'(FIFO_DEPTH);

    always_comb begin
        fifo_count_next = fifo_count_reg;
        case ({push, pop})
            2'b10:   fifo_count_next = fifo_count_reg + FCW'(1);
            2'b01:   fifo_count_next = fifo_count_reg - FCW'(1);
            default: fifo_count_next = fifo_count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end else begin
            fifo_count_reg <= fifo_count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTRW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTRW'(1);
            end
        end
        if (push) begin
            fifo_mem[wr_ptr_reg] <= result_word;
        end
    end

    assign m_tvalid = fifo_count_reg != '0;
    assign m_tdata  = M_TDATA_BITS'(fifo_mem[rd_ptr_reg]);

    // ---------------- checks ----------------
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending <= FCW'(FIFO_DEPTH))
        else $error("result credit exceeds queue depth");

    a_no_overflow_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_count_reg < FCW'(FIFO_DEPTH)) || pop)
        else $error("result pushed into a full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(MAX_VERTICES))
        else $error("vertex count beyond maximum");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (count_reg == '0) && prod_reg.valid && prod_reg.last)
        else $error("polygon state not restarted after last vertex");

    a_close_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (prod_reg.valid && prod_reg.last) |=> fin_reg.valid && !ovf_reg && !right_seen_reg)
        else $error("closing word lost between stages");

endmodule

`default_nettype wire

FILE: verif/polygon_area_checker.sv
// ----------------------------------------------------------------------------
// polygon_area_checker
// Watches both stream channels of the polygon area block, predicts each
// result word and compares it field by field.
//
// Every accepted vertex updates a private copy of the per-polygon state
// (first two vertices, last two kept vertices, signed shoelace sum, count,
// right-angle and overflow flags). A vertex with tlast closes the polygon and
// queues the expected report. Every accepted result word is checked against
// the oldest queued report. Mismatches and unexpected words are counted.
// ----------------------------------------------------------------------------
module polygon_area_checker
    import parstr_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [S_TDATA_BITS-1:0] s_tdata,
    input  wire logic                    s_tlast,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [M_TDATA_BITS-1:0] m_tdata,
    output int                           fail_count,
    output int                           reports_pending
);

    localparam longint AREA_LIMIT = (64'sd1 <<< AREA_BITS) - 1;

    typedef struct {
        logic [AREA_BITS-1:0]  twice_area;
        logic [COUNT_BITS-1:0] vertex_count;
        logic                  has_right_angle;
        logic                  too_many_vertices;
    } area_report_t;

    area_report_t expected_reports[$];

    longint poly_first_x, poly_first_y, poly_second_x, poly_second_y;
    longint poly_older_x, poly_older_y, poly_prev_x, poly_prev_y;
    longint shoelace_sum;
    int     poly_count;
    bit     poly_right;
    bit     poly_overflow;

    function automatic longint trapezoid_term(longint ax, longint ay, longint bx, longint by);
        return (ax + bx) * (ay - by);
    endfunction

    // b is the corner, a and c its neighbors
    function automatic bit is_square_corner(longint ax, longint ay, longint bx, longint by,
                                            longint cx, longint cy);
        return ((ax - bx) * (cx - bx) + (ay - by) * (cy - by)) == 0;
    endfunction

    task automatic clear_polygon();
        poly_first_x  = 0; poly_first_y  = 0;
        poly_second_x = 0; poly_second_y = 0;
        poly_older_x  = 0; poly_older_y  = 0;
        poly_prev_x   = 0; poly_prev_y   = 0;
        shoelace_sum  = 0;
        poly_count    = 0;
        poly_right    = 1'b0;
        poly_overflow = 1'b0;
    endtask

    task automatic take_vertex(logic signed [IN_COORD_BITS-1:0] raw_x,
                               logic signed [IN_COORD_BITS-1:0] raw_y, logic closing);
        longint       x;
        longint       y;
        longint       closed_sum;
        area_report_t report;
        x = longint'(raw_x);
        y = longint'(raw_y);
        if (poly_count < MAX_VERTICES_DEF) begin
            if (poly_count == 0) begin
                poly_first_x = x;
                poly_first_y = y;
            end else begin
                shoelace_sum += trapezoid_term(poly_prev_x, poly_prev_y, x, y);
                if (poly_count == 1) begin
                    poly_second_x = x;
                    poly_second_y = y;
                end else if (is_square_corner(poly_older_x, poly_older_y,
                                              poly_prev_x, poly_prev_y, x, y)) begin
                    poly_right = 1'b1;
                end
            end
            poly_older_x = poly_prev_x;
            poly_older_y = poly_prev_y;
            poly_prev_x  = x;
            poly_prev_y  = y;
            poly_count++;
        end else begin
            poly_overflow = 1'b1;
        end
        if (closing) begin
            report.twice_area      = '0;
            report.has_right_angle = 1'b0;
            if (poly_count >= MIN_VERTICES) begin
                closed_sum = shoelace_sum + trapezoid_term(poly_prev_x, poly_prev_y,
                                                           poly_first_x, poly_first_y);
                if (closed_sum < 0)
                    closed_sum = -closed_sum;
                if (closed_sum > AREA_LIMIT)
                    closed_sum = AREA_LIMIT;
                report.twice_area      = closed_sum[AREA_BITS-1:0];
                report.has_right_angle = poly_right
                    || is_square_corner(poly_older_x, poly_older_y, poly_prev_x, poly_prev_y,
                                        poly_first_x, poly_first_y)
                    || is_square_corner(poly_prev_x, poly_prev_y, poly_first_x, poly_first_y,
                                        poly_second_x, poly_second_y);
            end
            report.vertex_count      = poly_count[COUNT_BITS-1:0];
            report.too_many_vertices = poly_overflow;
            expected_reports.insert(expected_reports.size(), report);
            clear_polygon();
        end
    endtask

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    task automatic check_word(logic [M_TDATA_BITS-1:0] word);
        area_report_t want;
        if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual 0x%0h", $time, word);
            fail_count++;
        end else begin
            want = expected_reports.pop_front();
            check_field("twice_area", longint'(want.twice_area),
                        longint'(word[AREA_BITS-1:0]));
            check_field("vertex_count", longint'(want.vertex_count),
                        longint'(word[AREA_BITS +: COUNT_BITS]));
            check_field("has_right_angle", longint'(want.has_right_angle),
                        longint'(word[AREA_BITS+COUNT_BITS]));
            check_field("too_many_vertices", longint'(want.too_many_vertices),
                        longint'(word[AREA_BITS+COUNT_BITS+1]));
            check_field("pad", longint'(0), longint'(word[M_TDATA_BITS-1:RESULT_BITS]));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_polygon();
            expected_reports.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_word(m_tdata);
            if (s_tvalid && s_tready)
                take_vertex(s_tdata[IN_COORD_BITS-1:0],
                            s_tdata[2*IN_COORD_BITS-1:IN_COORD_BITS], s_tlast);
        end
        reports_pending = expected_reports.size();
    end

endmodule

FILE: verif/tb_polygon_area_right_angle_stream_top.sv
// ----------------------------------------------------------------------------
// tb_polygon_area_right_angle_stream_top
// Stimulus and verdict for the polygon area / right-angle stream block.
//
// Sends directed polygons (degenerate sizes, right angles at the first, a
// middle and the last vertex, extreme coordinates, repeated vertices), then
// one polygon at the vertex limit and one just past it, then random polygons
// in several coordinate styles. Both sides idle at random.
// The checker module predicts and compares; this module drives and reports.
// ----------------------------------------------------------------------------
module tb_polygon_area_right_angle_stream_top;
    import parstr_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 360;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [15:0] C_MAX = 16'h7FFF;
    localparam logic [15:0] C_MIN = 16'h8000;

    typedef enum int {
        STYLE_FULL,
        STYLE_NEAR,
        STYLE_GRID,
        STYLE_EDGE,
        STYLE_WIND
    } coord_style_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;
    int                      fail_count;
    int                      reports_pending;
    int                      cycle_count = 0;
    bit                      burst_mode;

    polygon_area_right_angle_stream_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    polygon_area_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .reports_pending (reports_pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic put_vertex(logic [15:0] vx, logic [15:0] vy, logic closing);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vy, vx};
        s_tlast  <= closing;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_polygon(int n, coord_style_t style);
        logic [15:0] vx;
        logic [15:0] vy;
        vx = 16'($urandom);
        vy = 16'($urandom);
        for (int i = 0; i < n; i++) begin
            case (style)
                STYLE_FULL: begin
                    vx = 16'($urandom);
                    vy = 16'($urandom);
                end
                STYLE_NEAR: begin
                    vx = 16'($urandom_range(0, 8) - 4);
                    vy = 16'($urandom_range(0, 8) - 4);
                end
                STYLE_GRID: begin
                    // axis-aligned walk, so most corners are square
                    if (i % 2)
                        vx = 16'(vx + $urandom_range(0, 2000) - 1000);
                    else if (i > 0)
                        vy = 16'(vy + $urandom_range(0, 2000) - 1000);
                end
                STYLE_EDGE: begin
                    case ($urandom_range(0, 3))
                        0: vx = C_MAX;
                        1: vx = C_MIN;
                        2: vx = 16'h0000;
                        default: vx = 16'hFFFF;
                    endcase
                    case ($urandom_range(0, 3))
                        0: vy = C_MAX;
                        1: vy = C_MIN;
                        2: vy = 16'h0000;
                        default: vy = 16'hFFFF;
                    endcase
                end
                default: begin
                    vx = (i % 4 == 0 || i % 4 == 3) ? C_MAX : C_MIN;
                    vy = (i % 4 < 2) ? C_MAX : C_MIN;
                end
            endcase
            put_vertex(vx, vy, i == n - 1);
        end
    endtask

    initial begin
        int           random_sent;
        int           n;
        int           pick;
        coord_style_t style;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        burst_mode = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single vertex, then two vertices
        put_vertex(C_MAX, C_MIN, 1'b1);
        put_vertex(C_MIN, C_MAX, 1'b0);
        put_vertex(C_MAX, C_MIN, 1'b1);
        // square corner at the first, a middle and the last vertex
        put_vertex(16'd0, 16'd0, 1'b0);
        put_vertex(16'd5, 16'd0, 1'b0);
        put_vertex(16'd0, 16'd5, 1'b1);
        put_vertex(16'd5, 16'd0, 1'b0);
        put_vertex(16'd0, 16'd0, 1'b0);
        put_vertex(16'd0, 16'd5, 1'b1);
        put_vertex(16'd5, 16'd0, 1'b0);
        put_vertex(16'd0, 16'd5, 1'b0);
        put_vertex(16'd0, 16'd0, 1'b1);
        // no square corner
        put_vertex(16'd0, 16'd0, 1'b0);
        put_vertex(16'd7, 16'd1, 1'b0);
        put_vertex(16'd2, 16'd9, 1'b1);
        // full-range triangle and square
        burst_mode = 1'b1;
        put_vertex(C_MIN, C_MIN, 1'b0);
        put_vertex(C_MAX, C_MIN, 1'b0);
        put_vertex(C_MAX, C_MAX, 1'b1);
        send_polygon(4, STYLE_WIND);
        burst_mode = 1'b0;
        // repeated vertex gives a zero-length edge
        put_vertex(16'd1, 16'd1, 1'b0);
        put_vertex(16'd1, 16'd1, 1'b0);
        put_vertex(16'd4, 16'd7, 1'b1);

        // at the vertex limit, and just past it
        send_polygon(MAX_VERTICES_DEF, STYLE_NEAR);
        send_polygon(MAX_VERTICES_DEF + 2, STYLE_GRID);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                n = $urandom_range(1, 2);
            else if (pick < 7)
                n = $urandom_range(3, 8);
            else if (pick < 9)
                n = $urandom_range(9, 24);
            else
                n = $urandom_range(25, 60);
            style      = coord_style_t'($urandom_range(STYLE_FULL, STYLE_WIND));
            burst_mode = ($urandom_range(0, 3) == 0);
            send_polygon(n, style);
            random_sent += n;
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (reports_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls with occasional stall-free stretches
    initial begin
        int stall;
        bit steady;
        m_tready = 1'b0;
        steady   = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                steady = !steady;
            stall = steady ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

endmodule
